[hw/rtl/tcw_pkg.sv]
// Shared types and constants of the text console writer.
package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELLS      = COLUMNS * ROWS;
	localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;
	localparam int TAB_STOP   = 8;

	localparam int ADDR_W   = 11;
	localparam int COL_W    = 7;
	localparam int ROW_W    = 5;
	localparam int CHAR_W   = 8;
	localparam int COLOUR_W = 4;
	localparam int CELL_W   = 16;

	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;

	localparam logic [COLOUR_W-1:0] RESET_FG = 4'd11;
	localparam logic [COLOUR_W-1:0] RESET_BG = 4'd0;
	localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_BG, RESET_FG, CH_SPACE};

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [0:0] {
		REG_FG = 1'b0,
		REG_BG = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_FILL,
		ST_SCROLL,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic fill;
		logic fill_init;
		logic scroll;
		logic finish;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic need_scroll;
		logic fill_done;
		logic scroll_done;
		logic out_free;
	} sts_t;

endpackage

[hw/rtl/tcw_in_if.sv]
// Input channel of the text console writer: one operation word.
interface tcw_in_if;
	logic                        valid;
	logic                        ready;
	tcw_pkg::op_t                opcode;
	logic [tcw_pkg::CHAR_W-1:0]  char_code;
	logic [tcw_pkg::ADDR_W-1:0]  cell_address;

	modport source (output valid, output opcode, output char_code, output cell_address,
		input ready);
	modport sink (input valid, input opcode, input char_code, input cell_address,
		output ready);
endinterface

[hw/rtl/tcw_out_if.sv]
// Output channel of the text console writer: one result word.
interface tcw_out_if;
	logic                        valid;
	logic                        ready;
	logic [tcw_pkg::ADDR_W-1:0]  cursor_location;
	logic [tcw_pkg::COL_W-1:0]   cursor_column;
	logic [tcw_pkg::ROW_W-1:0]   cursor_row;
	logic                        scrolled;
	logic [tcw_pkg::CELL_W-1:0]  cell_data;

	modport source (output valid, output cursor_location, output cursor_column,
		output cursor_row, output scrolled, output cell_data, input ready);
	modport sink (input valid, input cursor_location, input cursor_column,
		input cursor_row, input scrolled, input cell_data, output ready);
endinterface

[hw/rtl/text_console_writer.sv]
// Top level of the text console writer: an 80x25 text screen store with a cursor.
// The item channel carries one operation word: put a character, clear the
// screen, or read one cell. The result channel returns one word per item with
// the linear cursor location, its column and row, a scroll flag and, for a
// read, the cell contents (attribute byte above character byte).
// Colour registers are written on the cfg port: index 0 foreground, 1 background.
// Words are handled one at a time, so a new word is taken only after the last is through.
// A put without scroll, a read and the unused opcode pass from acceptance to a
// loaded result through accept, execute and load.
// A put that scrolls adds a scroll step, as the screen store moves one cell per
// cycle through its single write port; a clear adds a step of filling.
// After reset the store is filled with blanks, one cell per cycle, before the
// first word is accepted; colour writes are taken meanwhile.
// The result sits in an output register, so a new word is accepted while the
// previous result waits; a stalled receiver holds the next result back in the
// controller, and no word is accepted until that result is loaded.
module text_console_writer (
	input  logic                          clk,
	input  logic                          arst_n,
	tcw_in_if.sink                        item,
	tcw_out_if.source                     result,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [tcw_pkg::COLOUR_W-1:0]  cfg_wdata
);

	tcw_pkg::cmd_t cmd;
	tcw_pkg::sts_t sts;
	logic          in_ready;

	assign item.ready = in_ready;

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	tcw_datapath u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_wdata           (cfg_wdata),
		.in_opcode           (item.opcode),
		.in_char_code        (item.char_code),
		.in_cell_address     (item.cell_address),
		.out_valid           (result.valid),
		.out_ready           (result.ready),
		.out_cursor_location (result.cursor_location),
		.out_cursor_column   (result.cursor_column),
		.out_cursor_row      (result.cursor_row),
		.out_scrolled        (result.scrolled),
		.out_cell_data       (result.cell_data)
	);

endmodule

[hw/rtl/tcw_ctrl.sv]
// Controller state machine of the text console writer.
module tcw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output tcw_pkg::cmd_t cmd,
	input  tcw_pkg::sts_t sts
);

	tcw_pkg::state_t state_q;
	tcw_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			tcw_pkg::ST_INIT: begin
				cmd.fill      = 1'b1;
				cmd.fill_init = 1'b1;
				if (sts.fill_done) begin
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = tcw_pkg::ST_EXEC;
				end
			end
			tcw_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				case (sts.op)
					tcw_pkg::OP_CLEAR: state_d = tcw_pkg::ST_FILL;
					tcw_pkg::OP_PUT: begin
						state_d = sts.need_scroll ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_FINISH;
					end
					default: state_d = tcw_pkg::ST_FINISH;
				endcase
			end
			tcw_pkg::ST_FILL: begin
				cmd.fill = 1'b1;
				if (sts.fill_done) begin
					state_d = tcw_pkg::ST_FINISH;
				end
			end
			tcw_pkg::ST_SCROLL: begin
				cmd.scroll = 1'b1;
				if (sts.scroll_done) begin
					state_d = tcw_pkg::ST_FINISH;
				end
			end
			tcw_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = tcw_pkg::ST_IDLE;
				end
			end
			default: state_d = tcw_pkg::ST_INIT;
		endcase
	end

	// A result is only loaded when the output register can take it.
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("result loaded into a busy output register");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.exec, cmd.fill, cmd.scroll, cmd.finish}))
		else $error("more than one datapath command at once");

	// An accepted word is always followed by its execute cycle.
	a_load_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.exec)
		else $error("accepted word not executed");

endmodule

[hw/rtl/tcw_datapath.sv]
// Datapath of the text console writer: cursor, colours, screen store and result register.
module tcw_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tcw_pkg::cmd_t                   cmd,
	output tcw_pkg::sts_t                   sts,
	input  logic                            cfg_we,
	input  logic [0:0]                      cfg_index,
	input  logic [tcw_pkg::COLOUR_W-1:0]    cfg_wdata,
	input  tcw_pkg::op_t                    in_opcode,
	input  logic [tcw_pkg::CHAR_W-1:0]      in_char_code,
	input  logic [tcw_pkg::ADDR_W-1:0]      in_cell_address,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tcw_pkg::ADDR_W-1:0]      out_cursor_location,
	output logic [tcw_pkg::COL_W-1:0]       out_cursor_column,
	output logic [tcw_pkg::ROW_W-1:0]       out_cursor_row,
	output logic                            out_scrolled,
	output logic [tcw_pkg::CELL_W-1:0]      out_cell_data
);

	localparam int AW = tcw_pkg::ADDR_W;
	localparam int CW = tcw_pkg::COL_W;
	localparam int RW = tcw_pkg::ROW_W;

	logic [tcw_pkg::COLOUR_W-1:0] fg_q;
	logic [tcw_pkg::COLOUR_W-1:0] bg_q;
	logic [CW-1:0]                col_q;
	logic [RW-1:0]                row_q;
	logic [AW-1:0]                cnt_q;
	logic                         out_valid_q;
	logic                         scrolled_q;
	logic                         rd_hit_q;
	tcw_pkg::op_t                 op_q;
	logic [tcw_pkg::CHAR_W-1:0]   char_q;
	logic [AW-1:0]                addr_q;
	logic [tcw_pkg::CELL_W-1:0]   rdata_q;
	logic [tcw_pkg::CELL_W-1:0]   mem [tcw_pkg::CELLS];

	logic [CW-1:0]                col_n;
	logic [RW-1:0]                row_n;
	logic                         printable;
	logic                         need_scroll;
	logic                         rd_hit;
	logic [tcw_pkg::CELL_W-1:0]   blank;
	logic [AW-1:0]                cur_idx;
	logic                         mem_we;
	logic [AW-1:0]                mem_waddr;
	logic [tcw_pkg::CELL_W-1:0]   mem_wdata;
	logic                         mem_re;
	logic [AW-1:0]                mem_raddr;

	assign blank   = {bg_q, fg_q, tcw_pkg::CH_SPACE};
	assign cur_idx = AW'(row_q) * AW'(tcw_pkg::COLUMNS) + AW'(col_q);
	assign rd_hit  = addr_q < AW'(tcw_pkg::CELLS);

	// Cursor update of a put operation.
	always_comb begin
		col_n       = col_q;
		row_n       = row_q;
		printable   = 1'b0;
		need_scroll = 1'b0;
		if (char_q == tcw_pkg::CH_BS) begin
			if (col_q != '0) begin
				col_n = col_q - CW'(1);
			end
		end else if (char_q == tcw_pkg::CH_TAB) begin
			col_n = (col_q + CW'(tcw_pkg::TAB_STOP)) & ~CW'(tcw_pkg::TAB_STOP - 1);
		end else if (char_q == tcw_pkg::CH_CR) begin
			col_n = '0;
		end else if (char_q == tcw_pkg::CH_LF) begin
			col_n = '0;
			row_n = row_q + RW'(1);
		end else if (char_q inside {[tcw_pkg::CH_SPACE:tcw_pkg::CH_LAST]}) begin
			printable = 1'b1;
			col_n     = col_q + CW'(1);
		end
		if (col_n >= CW'(tcw_pkg::COLUMNS)) begin
			col_n = '0;
			row_n = row_n + RW'(1);
		end
		if (row_n >= RW'(tcw_pkg::ROWS)) begin
			need_scroll = 1'b1;
			row_n       = RW'(tcw_pkg::ROWS - 1);
		end
	end

	// Screen store port selection. A scroll reads one row ahead and writes
	// the word read in the previous cycle, then blanks the last row.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = blank;
		mem_re    = 1'b0;
		mem_raddr = addr_q;
		if (cmd.exec && op_q == tcw_pkg::OP_PUT && printable) begin
			mem_we    = 1'b1;
			mem_waddr = cur_idx;
			mem_wdata = {bg_q, fg_q, char_q};
		end
		if (cmd.exec && op_q == tcw_pkg::OP_READ && rd_hit) begin
			mem_re = 1'b1;
		end
		if (cmd.fill) begin
			mem_we    = 1'b1;
			mem_wdata = cmd.fill_init ? tcw_pkg::RESET_BLANK : blank;
		end
		if (cmd.scroll) begin
			mem_re    = cnt_q < AW'(tcw_pkg::COPY_CELLS);
			mem_raddr = cnt_q + AW'(tcw_pkg::COLUMNS);
			mem_we    = cnt_q != '0;
			mem_waddr = cnt_q - AW'(1);
			mem_wdata = (cnt_q <= AW'(tcw_pkg::COPY_CELLS)) ? rdata_q : blank;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_opcode;
			char_q <= in_char_code;
			addr_q <= in_cell_address;
		end
		if (cmd.exec) begin
			rd_hit_q <= rd_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q        <= tcw_pkg::RESET_FG;
			bg_q        <= tcw_pkg::RESET_BG;
			col_q       <= '0;
			row_q       <= '0;
			cnt_q       <= '0;
			scrolled_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tcw_pkg::REG_FG: fg_q <= cfg_wdata;
					tcw_pkg::REG_BG: bg_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.exec) begin
				cnt_q      <= '0;
				scrolled_q <= 1'b0;
				case (op_q)
					tcw_pkg::OP_PUT: begin
						col_q      <= col_n;
						row_q      <= row_n;
						scrolled_q <= need_scroll;
					end
					tcw_pkg::OP_CLEAR: begin
						col_q <= '0;
						row_q <= '0;
					end
					default: ;
				endcase
			end else if (cmd.fill || cmd.scroll) begin
				cnt_q <= cnt_q + AW'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_cursor_location <= cur_idx;
			out_cursor_column   <= col_q;
			out_cursor_row      <= row_q;
			out_scrolled        <= scrolled_q;
			out_cell_data       <= (op_q == tcw_pkg::OP_READ && rd_hit_q) ? rdata_q : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign sts.op          = op_q;
	assign sts.need_scroll = need_scroll;
	assign sts.fill_done   = cnt_q == AW'(tcw_pkg::CELLS - 1);
	assign sts.scroll_done = cnt_q == AW'(tcw_pkg::CELLS);
	assign sts.out_free    = !out_valid_q || out_ready;

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q < RW'(tcw_pkg::ROWS) && col_q < CW'(tcw_pkg::COLUMNS))
		else $error("cursor outside the screen");

	// A scrolled result always leaves the cursor on the bottom row.
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && scrolled_q |-> row_q == RW'(tcw_pkg::ROWS - 1))
		else $error("scroll did not leave cursor on last row");

	a_scroll_ports: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scroll && mem_we && mem_re |-> mem_waddr != mem_raddr)
		else $error("scroll read and write hit the same cell");

endmodule

[verif/testbench.sv]
// Self-checking testbench of the text console writer: mirrors the screen and cursor per word.
module testbench;

	localparam int QUIET_LIMIT = 20000;

	typedef struct {
		logic [tcw_pkg::ADDR_W-1:0] loc;
		logic [tcw_pkg::COL_W-1:0]  col;
		logic [tcw_pkg::ROW_W-1:0]  row;
		logic                       scrolled;
		logic [tcw_pkg::CELL_W-1:0] cell_data;
	} cursor_report_t;

	class console_mirror;
		logic [tcw_pkg::CELL_W-1:0]   screen [tcw_pkg::CELLS];
		int                           col;
		int                           row;
		logic [tcw_pkg::COLOUR_W-1:0] fg;
		logic [tcw_pkg::COLOUR_W-1:0] bg;
		cursor_report_t               pending_reports [$];
		int                           errors;

		function new();
			fg = tcw_pkg::RESET_FG;
			bg = tcw_pkg::RESET_BG;
			col = 0;
			row = 0;
			errors = 0;
			foreach (screen[i]) screen[i] = tcw_pkg::RESET_BLANK;
		endfunction

		function void set_colour(tcw_pkg::reg_idx_t idx, logic [tcw_pkg::COLOUR_W-1:0] value);
			if (idx == tcw_pkg::REG_FG) begin
				fg = value;
			end else begin
				bg = value;
			end
		endfunction

		function int location();
			return row * tcw_pkg::COLUMNS + col;
		endfunction

		function void note_word(tcw_pkg::op_t op, logic [tcw_pkg::CHAR_W-1:0] ch,
			logic [tcw_pkg::ADDR_W-1:0] addr);
			cursor_report_t rep;
			logic [tcw_pkg::CELL_W-1:0] fill;
			fill = {bg, fg, tcw_pkg::CH_SPACE};
			rep.scrolled = 1'b0;
			rep.cell_data = '0;
			case (op)
				tcw_pkg::OP_PUT: begin
					if (ch == tcw_pkg::CH_BS) begin
						if (col != 0) col--;
					end else if (ch == tcw_pkg::CH_TAB) begin
						col = (col + tcw_pkg::TAB_STOP) & ~(tcw_pkg::TAB_STOP - 1);
					end else if (ch == tcw_pkg::CH_CR) begin
						col = 0;
					end else if (ch == tcw_pkg::CH_LF) begin
						col = 0;
						row++;
					end else if (ch >= tcw_pkg::CH_SPACE && ch <= tcw_pkg::CH_LAST) begin
						screen[row * tcw_pkg::COLUMNS + col] = {bg, fg, ch};
						col++;
					end
					if (col >= tcw_pkg::COLUMNS) begin
						col = 0;
						row++;
					end
					if (row >= tcw_pkg::ROWS) begin
						for (int i = 0; i < tcw_pkg::COPY_CELLS; i++) begin
							screen[i] = screen[i + tcw_pkg::COLUMNS];
						end
						for (int i = tcw_pkg::COPY_CELLS; i < tcw_pkg::CELLS; i++) begin
							screen[i] = fill;
						end
						row = tcw_pkg::ROWS - 1;
						rep.scrolled = 1'b1;
					end
				end
				tcw_pkg::OP_CLEAR: begin
					foreach (screen[i]) screen[i] = fill;
					col = 0;
					row = 0;
				end
				tcw_pkg::OP_READ: begin
					if (addr < tcw_pkg::ADDR_W'(tcw_pkg::CELLS)) rep.cell_data = screen[addr];
				end
				default: begin
				end
			endcase
			rep.loc = tcw_pkg::ADDR_W'(location());
			rep.col = tcw_pkg::COL_W'(col);
			rep.row = tcw_pkg::ROW_W'(row);
			pending_reports.push_back(rep);
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 10) $display("%s", msg);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) report($sformatf("%s: expected 0x%0h, got 0x%0h", name, want, got));
		endfunction

		function void check_word(cursor_report_t got);
			cursor_report_t want;
			if (pending_reports.size() == 0) begin
				report($sformatf("Result word with nothing expected: location %0d", got.loc));
				return;
			end
			want = pending_reports.pop_front();
			compare_field("cursor_location", 32'(want.loc), 32'(got.loc));
			compare_field("cursor_column", 32'(want.col), 32'(got.col));
			compare_field("cursor_row", 32'(want.row), 32'(got.row));
			compare_field("scrolled", 32'(want.scrolled), 32'(got.scrolled));
			compare_field("cell_data", 32'(want.cell_data), 32'(got.cell_data));
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [0:0]                   cfg_index;
	logic [tcw_pkg::COLOUR_W-1:0] cfg_wdata;

	tcw_in_if  in_ch ();
	tcw_out_if out_ch ();

	text_console_writer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (in_ch),
		.result    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	console_mirror mirror;
	bit            no_idle = 1'b0;
	int            hold_cycles = 0;
	int            quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ch.ready = 1'b0;
				hold_cycles--;
			end else begin
				out_ch.ready = no_idle || ($urandom_range(99) >= 31);
			end
		end
	end

	always @(posedge clk) begin
		cursor_report_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.loc = out_ch.cursor_location;
			got.col = out_ch.cursor_column;
			got.row = out_ch.cursor_row;
			got.scrolled = out_ch.scrolled;
			got.cell_data = out_ch.cell_data;
			mirror.check_word(got);
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** text_console_writer: FAILED **");
			$finish;
		end
	end

	task automatic send_word(tcw_pkg::op_t op, logic [tcw_pkg::CHAR_W-1:0] ch,
		logic [tcw_pkg::ADDR_W-1:0] addr);
		while (!no_idle && $urandom_range(99) < 31) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.opcode = op;
		in_ch.char_code = ch;
		in_ch.cell_address = addr;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		mirror.note_word(op, ch, addr);
		@(negedge clk);
	endtask

	task automatic put_char(logic [tcw_pkg::CHAR_W-1:0] ch);
		send_word(tcw_pkg::OP_PUT, ch, tcw_pkg::ADDR_W'($urandom));
	endtask

	task automatic read_cell(logic [tcw_pkg::ADDR_W-1:0] addr);
		send_word(tcw_pkg::OP_READ, tcw_pkg::CHAR_W'($urandom), addr);
	endtask

	task automatic write_colour(tcw_pkg::reg_idx_t idx, logic [tcw_pkg::COLOUR_W-1:0] value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		mirror.set_colour(idx, value);
	endtask

	task automatic drain();
		in_ch.valid = 1'b0;
		while (mirror.pending_reports.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic directed_words();
		read_cell(tcw_pkg::ADDR_W'(0));
		read_cell(tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1));
		read_cell(tcw_pkg::ADDR_W'(tcw_pkg::CELLS));
		read_cell(11'h7FF);
		put_char(tcw_pkg::CH_BS);
		put_char(8'h41);
		put_char(tcw_pkg::CH_SPACE);
		put_char(tcw_pkg::CH_LAST);
		put_char(tcw_pkg::CH_BS);
		put_char(tcw_pkg::CH_TAB);
		put_char(8'h1F);
		put_char(8'h80);
		put_char(8'hFF);
		put_char(8'h00);
		put_char(tcw_pkg::CH_CR);
		put_char(tcw_pkg::CH_LF);
		send_word(tcw_pkg::OP_NOP, tcw_pkg::CHAR_W'($urandom), tcw_pkg::ADDR_W'($urandom));
		read_cell(tcw_pkg::ADDR_W'(0));
		read_cell(tcw_pkg::ADDR_W'(1));
		send_word(tcw_pkg::OP_CLEAR, tcw_pkg::CHAR_W'($urandom), tcw_pkg::ADDR_W'($urandom));
		read_cell(tcw_pkg::ADDR_W'(0));
	endtask

	task automatic random_traffic(int count);
		int sent;
		int kind;
		int n;
		int pick;
		int base;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(99);
			if (kind < 45) begin
				n = $urandom_range(5, 40);
				repeat (n) begin
					pick = $urandom_range(99);
					if (pick < 85) begin
						put_char(tcw_pkg::CHAR_W'($urandom_range(tcw_pkg::CH_SPACE,
							tcw_pkg::CH_LAST)));
					end else if (pick < 90) put_char(tcw_pkg::CH_TAB);
					else if (pick < 94) put_char(tcw_pkg::CH_BS);
					else if (pick < 97) put_char(tcw_pkg::CH_CR);
					else put_char(tcw_pkg::CH_LF);
				end
			end else if (kind < 55) begin
				n = $urandom_range(1, 25);
				repeat (n) put_char(tcw_pkg::CH_LF);
			end else if (kind < 62) begin
				n = $urandom_range(1, 12);
				repeat (n) put_char(tcw_pkg::CH_TAB);
			end else if (kind < 80) begin
				n = $urandom_range(1, 8);
				repeat (n) begin
					pick = $urandom_range(99);
					if (pick < 50) begin
						base = mirror.location() - $urandom_range(0, 120);
						if (base < 0) base = 0;
						read_cell(tcw_pkg::ADDR_W'(base));
					end else if (pick < 80) begin
						read_cell(tcw_pkg::ADDR_W'($urandom_range(0, tcw_pkg::CELLS - 1)));
					end else begin
						read_cell(tcw_pkg::ADDR_W'($urandom));
					end
				end
			end else if (kind < 83) begin
				n = 1;
				send_word(tcw_pkg::OP_CLEAR, tcw_pkg::CHAR_W'($urandom),
					tcw_pkg::ADDR_W'($urandom));
			end else begin
				n = $urandom_range(1, 5);
				repeat (n) send_word(tcw_pkg::op_t'($urandom_range(0, 3)),
					tcw_pkg::CHAR_W'($urandom), tcw_pkg::ADDR_W'($urandom));
			end
			sent += n;
		end
	endtask

	initial begin
		logic [tcw_pkg::COLOUR_W-1:0] fg_plan [5];
		logic [tcw_pkg::COLOUR_W-1:0] bg_plan [5];
		fg_plan = '{4'd15, 4'd0, 4'd0, 4'd15, 4'd0};
		bg_plan = '{4'd0, 4'd15, 4'd0, 4'd15, 4'd0};
		fg_plan[2] = tcw_pkg::COLOUR_W'($urandom);
		bg_plan[2] = tcw_pkg::COLOUR_W'($urandom);
		mirror = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = tcw_pkg::REG_FG;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.opcode = tcw_pkg::OP_PUT;
		in_ch.char_code = '0;
		in_ch.cell_address = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		directed_words();
		drain();
		for (int phase = 0; phase < 5; phase++) begin
			write_colour(tcw_pkg::REG_FG, fg_plan[phase]);
			write_colour(tcw_pkg::REG_BG, bg_plan[phase]);
			no_idle = (phase == 2);
			if (phase == 3) hold_cycles = 400;
			random_traffic(78);
			drain();
		end
		repeat (20) @(negedge clk);
		if (mirror.errors == 0 && mirror.pending_reports.size() == 0) begin
			$display("** text_console_writer: PASSED **");
		end else begin
			$display("** text_console_writer: FAILED **");
		end
		$finish;
	end

endmodule

[text_console_writer.f]
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_in_if.sv
hw/rtl/tcw_out_if.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/tcw_datapath.sv
hw/rtl/text_console_writer.sv
verif/testbench.sv
